@@ rtl/bis_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared widths, register indexes, reset values, controller states and the
// command and status structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MAX_WIDTH       = 256;
    localparam int MAX_HEIGHT      = 256;
    localparam int WEIGHT_BITS     = 8;

    localparam int COORD_BITS      = 10;
    localparam int CHAN_BITS       = 8;
    localparam int PIXEL_BITS      = 3 * CHAN_BITS;
    localparam int SIZE_BITS       = 9;
    localparam int SCALE_BITS      = 16;
    localparam int SCALE_FRAC_BITS = 14;

    localparam int COL_BITS        = $clog2(MAX_WIDTH);
    localparam int ROW_BITS        = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS       = $clog2(STORE_DEPTH);

    localparam int POS_BITS        = COORD_BITS + SCALE_BITS;
    localparam int IP_BITS         = POS_BITS - SCALE_FRAC_BITS;
    localparam int FW_BITS         = WEIGHT_BITS + 1;
    localparam int WGT_BITS        = 2 * WEIGHT_BITS + 1;
    localparam int ACC_BITS        = 2 * WEIGHT_BITS + CHAN_BITS;

    localparam int CFG_ADDR_BITS   = 2;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SOURCE_WIDTH    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SOURCE_HEIGHT   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INVERSE_SCALE_X = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INVERSE_SCALE_Y = 2'd3;

    localparam logic [SIZE_BITS-1:0]  RESET_SOURCE_SIZE   = 9'd128;
    localparam logic [SCALE_BITS-1:0] RESET_INVERSE_SCALE = 16'd10923;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_MAP,
        S_CLAMP,
        S_FETCH,
        S_LAST,
        S_EMIT
    } bis_state_t;

    typedef struct packed {
        logic       capture;
        logic       write_pixel;
        logic       map;
        logic       clamp;
        logic       fetch;
        logic [1:0] sel;
        logic       accumulate;
        logic       emit;
    } bis_cmd_t;

    typedef struct packed {
        logic out_free;
    } bis_status_t;

endpackage
`default_nettype wire

@@ rtl/bis_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler controller
// Sequences one item at a time: a store write for a load, and mapping,
// clamping, four neighbour fetches and the result hand-over for a query.
// ----------------------------------------------------------------------------
module bis_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                command,
    output logic                     in_stall,
    input  wire bis_pkg::bis_status_t status,
    output bis_pkg::bis_cmd_t        cmd
);
    import bis_pkg::*;

    bis_state_t state_reg;
    bis_state_t state_next;
    logic [1:0] sel_reg;
    logic [1:0] sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == CMD_QUERY) ? S_MAP : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_MAP:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = S_FETCH;
                sel_next   = 2'd0;
            end
            S_FETCH:
            begin
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd3)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = sel_reg;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_WRITE:
            begin
                cmd.write_pixel = 1'b1;
            end
            S_MAP:
            begin
                cmd.map = 1'b1;
            end
            S_CLAMP:
            begin
                cmd.clamp = 1'b1;
            end
            S_FETCH:
            begin
                cmd.fetch      = 1'b1;
                cmd.accumulate = (sel_reg != 2'd0);
            end
            S_LAST:
            begin
                cmd.accumulate = 1'b1;
            end
            S_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/bis_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler datapath
// Holds the configuration registers, the frame store, the coordinate mapping,
// the edge clamping, the weight generation and the per-channel accumulators.
// ----------------------------------------------------------------------------
module bis_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [bis_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [bis_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  wire logic [bis_pkg::COORD_BITS-1:0]        coord_x,
    input  wire logic [bis_pkg::COORD_BITS-1:0]        coord_y,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]         in_red,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]         in_green,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]         in_blue,
    input  wire bis_pkg::bis_cmd_t                     cmd,
    output bis_pkg::bis_status_t                       status,
    input  wire logic                                  out_stall,
    output logic                                       out_valid,
    output logic [bis_pkg::CHAN_BITS-1:0]              out_red,
    output logic [bis_pkg::CHAN_BITS-1:0]              out_green,
    output logic [bis_pkg::CHAN_BITS-1:0]              out_blue
);
    import bis_pkg::*;

    localparam logic [FW_BITS-1:0] WEIGHT_ONE = FW_BITS'(1 << WEIGHT_BITS);

    logic [SIZE_BITS-1:0]  source_width_reg;
    logic [SIZE_BITS-1:0]  source_height_reg;
    logic [SCALE_BITS-1:0] inverse_scale_x_reg;
    logic [SCALE_BITS-1:0] inverse_scale_y_reg;

    logic [COORD_BITS-1:0] coord_x_reg;
    logic [COORD_BITS-1:0] coord_y_reg;
    logic [PIXEL_BITS-1:0] pixel_reg;

    logic [POS_BITS-1:0]    pos_x_reg;
    logic [POS_BITS-1:0]    pos_y_reg;
    logic [COL_BITS-1:0]    x0_reg;
    logic [COL_BITS-1:0]    x1_reg;
    logic [ROW_BITS-1:0]    y0_reg;
    logic [ROW_BITS-1:0]    y1_reg;
    logic [WEIGHT_BITS-1:0] fx_reg;
    logic [WEIGHT_BITS-1:0] fy_reg;
    logic [WGT_BITS-1:0]    wgt_reg;
    logic [PIXEL_BITS-1:0]  rd_data_reg;
    logic [ACC_BITS-1:0]    acc_reg [3];

    logic                  out_valid_reg;
    logic [CHAN_BITS-1:0]  out_red_reg;
    logic [CHAN_BITS-1:0]  out_green_reg;
    logic [CHAN_BITS-1:0]  out_blue_reg;

    logic [PIXEL_BITS-1:0] frame_store [STORE_DEPTH];

    logic [COL_BITS-1:0]    last_x;
    logic [ROW_BITS-1:0]    last_y;
    logic [IP_BITS-1:0]     ip_x;
    logic [IP_BITS-1:0]     ip_y;
    logic [IP_BITS:0]       ip_x1;
    logic [IP_BITS:0]       ip_y1;
    logic [COL_BITS-1:0]    x0_next;
    logic [COL_BITS-1:0]    x1_next;
    logic [ROW_BITS-1:0]    y0_next;
    logic [ROW_BITS-1:0]    y1_next;
    logic [FW_BITS-1:0]     wa;
    logic [FW_BITS-1:0]     wb;
    logic [2*FW_BITS-1:0]   wprod;
    logic [WGT_BITS+CHAN_BITS-1:0] chan_prod [3];
    logic                   load_in_range;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [COL_BITS-1:0]    rd_col;
    logic [ROW_BITS-1:0]    rd_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg    <= RESET_SOURCE_SIZE;
            source_height_reg   <= RESET_SOURCE_SIZE;
            inverse_scale_x_reg <= RESET_INVERSE_SCALE;
            inverse_scale_y_reg <= RESET_INVERSE_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_SOURCE_WIDTH:    source_width_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_INVERSE_SCALE_X: inverse_scale_x_reg <= cfg_data[SCALE_BITS-1:0];
                REG_INVERSE_SCALE_Y: inverse_scale_y_reg <= cfg_data[SCALE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A zero size acts as one, and a size beyond the store saturates.
    always_comb
    begin
        if (source_width_reg == '0)
        begin
            last_x = '0;
        end
        else if (32'(source_width_reg) > MAX_WIDTH)
        begin
            last_x = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            last_x = COL_BITS'(source_width_reg - 1'b1);
        end

        if (source_height_reg == '0)
        begin
            last_y = '0;
        end
        else if (32'(source_height_reg) > MAX_HEIGHT)
        begin
            last_y = ROW_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            last_y = ROW_BITS'(source_height_reg - 1'b1);
        end
    end

    assign ip_x  = pos_x_reg[POS_BITS-1:SCALE_FRAC_BITS];
    assign ip_y  = pos_y_reg[POS_BITS-1:SCALE_FRAC_BITS];
    assign ip_x1 = {1'b0, ip_x} + 1'b1;
    assign ip_y1 = {1'b0, ip_y} + 1'b1;

    assign x0_next = (ip_x > IP_BITS'(last_x)) ? last_x : COL_BITS'(ip_x);
    assign x1_next = (ip_x1 > (IP_BITS+1)'(last_x)) ? last_x : COL_BITS'(ip_x1);
    assign y0_next = (ip_y > IP_BITS'(last_y)) ? last_y : ROW_BITS'(ip_y);
    assign y1_next = (ip_y1 > (IP_BITS+1)'(last_y)) ? last_y : ROW_BITS'(ip_y1);

    assign wa    = cmd.sel[0] ? {1'b0, fx_reg} : WEIGHT_ONE - {1'b0, fx_reg};
    assign wb    = cmd.sel[1] ? {1'b0, fy_reg} : WEIGHT_ONE - {1'b0, fy_reg};
    assign wprod = wa * wb;

    assign rd_col  = cmd.sel[0] ? x1_reg : x0_reg;
    assign rd_row  = cmd.sel[1] ? y1_reg : y0_reg;
    assign rd_addr = ADDR_BITS'(ADDR_BITS'(rd_row) * ADDR_BITS'(MAX_WIDTH))
                   + ADDR_BITS'(rd_col);

    assign load_in_range = (32'(coord_x_reg) < MAX_WIDTH) && (32'(coord_y_reg) < MAX_HEIGHT);
    assign wr_addr = ADDR_BITS'(ADDR_BITS'(coord_y_reg) * ADDR_BITS'(MAX_WIDTH))
                   + ADDR_BITS'(coord_x_reg);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chan_prod[c] = wgt_reg * rd_data_reg[(2 - c) * CHAN_BITS +: CHAN_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            coord_x_reg <= coord_x;
            coord_y_reg <= coord_y;
            pixel_reg   <= {in_red, in_green, in_blue};
        end
        if (cmd.map)
        begin
            pos_x_reg <= POS_BITS'(coord_x_reg) * POS_BITS'(inverse_scale_x_reg);
            pos_y_reg <= POS_BITS'(coord_y_reg) * POS_BITS'(inverse_scale_y_reg);
        end
        if (cmd.clamp)
        begin
            x0_reg <= x0_next;
            x1_reg <= x1_next;
            y0_reg <= y0_next;
            y1_reg <= y1_next;
            fx_reg <= pos_x_reg[SCALE_FRAC_BITS-1 -: WEIGHT_BITS];
            fy_reg <= pos_y_reg[SCALE_FRAC_BITS-1 -: WEIGHT_BITS];
        end
        if (cmd.fetch)
        begin
            wgt_reg <= wprod[WGT_BITS-1:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.clamp)
            begin
                acc_reg[c] <= '0;
            end
            else if (cmd.accumulate)
            begin
                acc_reg[c] <= acc_reg[c] + chan_prod[c][ACC_BITS-1:0];
            end
        end
        if (cmd.emit)
        begin
            out_red_reg   <= acc_reg[0][ACC_BITS-1 -: CHAN_BITS];
            out_green_reg <= acc_reg[1][ACC_BITS-1 -: CHAN_BITS];
            out_blue_reg  <= acc_reg[2][ACC_BITS-1 -: CHAN_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_pixel && load_in_range)
        begin
            frame_store[wr_addr] <= pixel_reg;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= frame_store[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

endmodule
`default_nettype wire

@@ rtl/bilinear_image_scaler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bilinear image scaler core
// A load writes the frame store in the WRITE state; a query maps, clamps,
// makes four single-port reads of the frame store and accumulates before
// its result is registered. One item is in work at a time; a finished result
// waits in the output register. Reset restores the controller and the
// configuration registers to their defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [bis_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [bis_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic [bis_pkg::COORD_BITS-1:0]     coord_x,
    input  wire logic [bis_pkg::COORD_BITS-1:0]     coord_y,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]      in_red,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]      in_green,
    input  wire logic [bis_pkg::CHAN_BITS-1:0]      in_blue,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [bis_pkg::CHAN_BITS-1:0]           out_red,
    output logic [bis_pkg::CHAN_BITS-1:0]           out_green,
    output logic [bis_pkg::CHAN_BITS-1:0]           out_blue
);
    import bis_pkg::*;

    bis_cmd_t    cmd;
    bis_status_t status;

    bis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bis_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .cmd       (cmd),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule
`default_nettype wire
